/* src/avrid_pkg.sv */
// Shared types and constants for the AVR instruction decoder.
// Holds the operation kind codes, the result word layout and the group lookup functions.
// No dependencies.
`default_nettype none

package avrid_pkg;

    typedef enum logic [4:0] {
        OP_NOP     = 5'd0,
        OP_MOVW    = 5'd1,
        OP_MULS    = 5'd2,
        OP_MULSU   = 5'd3,
        OP_FMUL    = 5'd4,
        OP_FMULS   = 5'd5,
        OP_FMULSU  = 5'd6,
        OP_CP      = 5'd7,
        OP_CPC     = 5'd8,
        OP_SUB     = 5'd9,
        OP_SBC     = 5'd10,
        OP_ADD     = 5'd11,
        OP_LSL     = 5'd12,
        OP_ADC     = 5'd13,
        OP_ROL     = 5'd14,
        OP_CPSE    = 5'd15,
        OP_AND     = 5'd16,
        OP_EOR     = 5'd17,
        OP_OR      = 5'd18,
        OP_MOV     = 5'd19,
        OP_CPI     = 5'd20,
        OP_SUBI    = 5'd21,
        OP_SBCI    = 5'd22,
        OP_ORI     = 5'd23,
        OP_ANDI    = 5'd24,
        OP_LDD     = 5'd25,
        OP_STD     = 5'd26,
        OP_LDS     = 5'd27,
        OP_STS     = 5'd28,
        OP_UNKNOWN = 5'd29
    } op_kind_t;

    localparam int InWidth  = 32;
    localparam int OutWidth = 48;

    // The first member sits in the highest bits, so the list runs from the top field down.
    typedef struct packed {
        logic [1:0]  word_count;
        logic [15:0] data_address;
        logic        use_y_pointer;
        logic [5:0]  displacement;
        logic [7:0]  immediate;
        logic [4:0]  src_reg;
        logic [4:0]  dest_reg;
        op_kind_t    op_kind;
    } result_t;

    function automatic op_kind_t two_reg_kind(input logic [3:0] sel);
        op_kind_t k;
        case (sel)
            4'd1:    k = OP_CPC;
            4'd2:    k = OP_SBC;
            4'd3:    k = OP_ADD;
            4'd4:    k = OP_CPSE;
            4'd5:    k = OP_CP;
            4'd6:    k = OP_SUB;
            4'd7:    k = OP_ADC;
            4'd8:    k = OP_AND;
            4'd9:    k = OP_EOR;
            4'd10:   k = OP_OR;
            4'd11:   k = OP_MOV;
            default: k = OP_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic op_kind_t imm_kind(input logic [2:0] sel);
        op_kind_t k;
        case (sel)
            3'd3:    k = OP_CPI;
            3'd4:    k = OP_SBCI;
            3'd5:    k = OP_SUBI;
            3'd6:    k = OP_ORI;
            3'd7:    k = OP_ANDI;
            default: k = OP_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic op_kind_t mul_kind(input logic [1:0] sel);
        op_kind_t k;
        case (sel)
            2'd0:    k = OP_MULSU;
            2'd1:    k = OP_FMUL;
            2'd2:    k = OP_FMULS;
            default: k = OP_FMULSU;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

/* src/avr_instruction_decoder.sv */
// Stream wrapper of the AVR instruction decoder: decode logic, output register and skid register.
// Depends on avrid_pkg and avrid_decode.
// An accepted word's result is registered in the output register, or in the skid register while the output stalls.
// Throughput is one word per cycle while results are taken; the skid register holds one word when a result stalls.
// Reset (aresetn low, synchronous) empties both registers; no other state exists.
`default_nettype none

module avr_instruction_decoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output wire logic                          s_tready,
    // Fields from bit 0 up: instr_word[15:0], next_word[31:16].
    input  wire logic [avrid_pkg::InWidth-1:0] s_tdata,
    output wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    // Fields from bit 0 up: op_kind[4:0], dest_reg[9:5], src_reg[14:10], immediate[22:15],
    // displacement[28:23], use_y_pointer[29], data_address[45:30], word_count[47:46].
    output wire logic [avrid_pkg::OutWidth-1:0] m_tdata
);
    import avrid_pkg::*;

    result_t dec_result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    logic    s_accept;
    logic    m_accept;

    avrid_decode u_decode (
        .instr_word (s_tdata[15:0]),
        .next_word  (s_tdata[31:16]),
        .result     (dec_result)
    );

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && !skid_valid_reg;
    assign m_accept = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_accept) begin
            out_valid_next  = skid_valid_reg || s_accept;
            skid_valid_next = 1'b0;
        end else if (s_accept) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_accept) begin
            out_reg <= skid_valid_reg ? skid_reg : dec_result;
        end
        if (s_accept && out_valid_reg && !m_accept) begin
            skid_reg <= dec_result;
        end
    end

endmodule

`default_nettype wire

/* src/avrid_decode.sv */
// Combinational decode of one AVR instruction word into its kind and operands.
// Depends on avrid_pkg for the kind codes and the result layout.
`default_nettype none

module avrid_decode (
    input  wire logic [15:0]       instr_word,
    input  wire logic [15:0]       next_word,
    output avrid_pkg::result_t     result
);
    import avrid_pkg::*;

    logic [7:0] hi;
    logic [7:0] lo;
    logic [4:0] d5;
    logic [4:0] r5;
    op_kind_t   tr_kind;

    assign hi      = instr_word[15:8];
    assign lo      = instr_word[7:0];
    assign d5      = {hi[0], lo[7:4]};
    assign r5      = {hi[1], lo[3:0]};
    assign tr_kind = two_reg_kind(hi[5:2]);

    always_comb begin
        result               = '0;
        result.op_kind       = OP_UNKNOWN;
        result.word_count    = 2'd1;
        if (instr_word == 16'h0000) begin
            result.op_kind = OP_NOP;
        end else if (hi == 8'h01) begin
            result.op_kind  = OP_MOVW;
            result.dest_reg = {lo[7:4], 1'b0};
            result.src_reg  = {lo[3:0], 1'b0};
        end else if (hi == 8'h02) begin
            result.op_kind  = OP_MULS;
            result.dest_reg = {1'b1, lo[7:4]};
            result.src_reg  = {1'b1, lo[3:0]};
        end else if (hi == 8'h03) begin
            result.op_kind  = mul_kind({lo[7], lo[3]});
            result.dest_reg = {2'b10, lo[6:4]};
            result.src_reg  = {2'b10, lo[2:0]};
        end else if (hi[7:6] == 2'b00 && hi[5:2] >= 4'd1 && hi[5:2] <= 4'd11) begin
            result.op_kind  = tr_kind;
            result.dest_reg = d5;
            result.src_reg  = r5;
            if (d5 == r5 && tr_kind == OP_ADD) begin
                result.op_kind = OP_LSL;
                result.src_reg = '0;
            end else if (d5 == r5 && tr_kind == OP_ADC) begin
                result.op_kind = OP_ROL;
                result.src_reg = '0;
            end
        end else if (hi[7:4] >= 4'd3 && hi[7:4] <= 4'd7) begin
            result.op_kind   = imm_kind(hi[6:4]);
            result.dest_reg  = {1'b1, lo[7:4]};
            result.immediate = {hi[3:0], lo[3:0]};
        end else if (hi[7] && !hi[6] && !hi[4]) begin
            result.op_kind       = hi[1] ? OP_STD : OP_LDD;
            result.dest_reg      = d5;
            result.displacement  = {hi[5], hi[3:2], lo[2:0]};
            result.use_y_pointer = lo[3];
        end else if (hi[7:2] == 6'b100100 && lo[3:0] == 4'h0) begin
            result.op_kind      = hi[1] ? OP_STS : OP_LDS;
            result.dest_reg     = d5;
            result.data_address = next_word;
            result.word_count   = 2'd2;
        end
    end

endmodule

`default_nettype wire

/* bench/avr_decode_checker.sv */
`timescale 1ns / 1ps
// Checker for the AVR instruction decoder: watches both stream channels, decodes each accepted
// input word on its own and compares every result word field by field in order.
// Depends on avrid_pkg for the operation kinds and the result word layout.

module avr_decode_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // Fields from bit 0 up: instr_word, next_word.
    input  logic [avrid_pkg::InWidth-1:0]  s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0 up: op_kind, dest_reg, src_reg, immediate, displacement,
    // use_y_pointer, data_address, word_count.
    input  logic [avrid_pkg::OutWidth-1:0] m_tdata,
    output int                            fail_count,
    output int                            outstanding
);
    import avrid_pkg::*;

    result_t decoded_words[$];
    result_t want;
    result_t got;

    function automatic result_t decode_avr_word(input logic [15:0] w, input logic [15:0] nxt);
        result_t    r;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [4:0] d5;
        logic [4:0] r5;
        logic [3:0] sel;
        r = '0;
        r.op_kind = OP_UNKNOWN;
        r.word_count = 2'd1;
        hi = w[15:8];
        lo = w[7:0];
        d5 = {w[8], w[7:4]};
        r5 = {w[9], w[3:0]};
        sel = w[13:10];
        if (w == 16'h0000) begin
            r.op_kind = OP_NOP;
        end else if (hi == 8'h01) begin
            r.op_kind = OP_MOVW;
            r.dest_reg = {lo[7:4], 1'b0};
            r.src_reg = {lo[3:0], 1'b0};
        end else if (hi == 8'h02) begin
            r.op_kind = OP_MULS;
            r.dest_reg = {1'b1, lo[7:4]};
            r.src_reg = {1'b1, lo[3:0]};
        end else if (hi == 8'h03) begin
            case ({lo[7], lo[3]})
                2'b00:   r.op_kind = OP_MULSU;
                2'b01:   r.op_kind = OP_FMUL;
                2'b10:   r.op_kind = OP_FMULS;
                default: r.op_kind = OP_FMULSU;
            endcase
            r.dest_reg = {2'b10, lo[6:4]};
            r.src_reg = {2'b10, lo[2:0]};
        end else if (w[15:14] == 2'b00 && sel >= 4'd1 && sel <= 4'd11) begin
            case (sel)
                4'd1:    r.op_kind = OP_CPC;
                4'd2:    r.op_kind = OP_SBC;
                4'd3:    r.op_kind = OP_ADD;
                4'd4:    r.op_kind = OP_CPSE;
                4'd5:    r.op_kind = OP_CP;
                4'd6:    r.op_kind = OP_SUB;
                4'd7:    r.op_kind = OP_ADC;
                4'd8:    r.op_kind = OP_AND;
                4'd9:    r.op_kind = OP_EOR;
                4'd10:   r.op_kind = OP_OR;
                default: r.op_kind = OP_MOV;
            endcase
            r.dest_reg = d5;
            r.src_reg = r5;
            // With both operands equal, add and adc are the one-operand shifts.
            if (d5 == r5 && r.op_kind == OP_ADD) begin
                r.op_kind = OP_LSL;
                r.src_reg = '0;
            end else if (d5 == r5 && r.op_kind == OP_ADC) begin
                r.op_kind = OP_ROL;
                r.src_reg = '0;
            end
        end else if (w[15:12] >= 4'd3 && w[15:12] <= 4'd7) begin
            case (w[14:12])
                3'd3:    r.op_kind = OP_CPI;
                3'd4:    r.op_kind = OP_SBCI;
                3'd5:    r.op_kind = OP_SUBI;
                3'd6:    r.op_kind = OP_ORI;
                default: r.op_kind = OP_ANDI;
            endcase
            r.dest_reg = {1'b1, lo[7:4]};
            r.immediate = {hi[3:0], lo[3:0]};
        end else if (hi[7] && !hi[6] && !hi[4]) begin
            r.op_kind = hi[1] ? OP_STD : OP_LDD;
            r.dest_reg = d5;
            r.displacement = {hi[5], hi[3:2], lo[2:0]};
            r.use_y_pointer = lo[3];
        end else if (hi[7:2] == 6'b100100 && lo[3:0] == 4'h0) begin
            r.op_kind = hi[1] ? OP_STS : OP_LDS;
            r.dest_reg = d5;
            r.data_address = nxt;
            r.word_count = 2'd2;
        end
        return r;
    endfunction

    task automatic compare_field(input string field, input int unsigned want_v,
                                 input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                decoded_words.push_back(decode_avr_word(s_tdata[15:0], s_tdata[31:16]));
            end
            if (m_tvalid && m_tready) begin
                if (decoded_words.size() == 0) begin
                    $display("%0t: result word %h arrived with none expected, expected nothing",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = decoded_words.pop_front();
                    got = result_t'(m_tdata);
                    compare_field("op_kind", want.op_kind, got.op_kind);
                    compare_field("dest_reg", want.dest_reg, got.dest_reg);
                    compare_field("src_reg", want.src_reg, got.src_reg);
                    compare_field("immediate", want.immediate, got.immediate);
                    compare_field("displacement", want.displacement, got.displacement);
                    compare_field("use_y_pointer", want.use_y_pointer, got.use_y_pointer);
                    compare_field("data_address", want.data_address, got.data_address);
                    compare_field("word_count", want.word_count, got.word_count);
                end
            end
            outstanding = decoded_words.size();
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Top of the AVR instruction decoder testbench: clock, reset, stimulus and verdict.
// Depends on avrid_pkg, avr_instruction_decoder and avr_decode_checker.

module tb_top;
    import avrid_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int HoldCycles = 300;
    localparam int PhaseWords = 280;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [InWidth-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutWidth-1:0] m_tdata;
    int                  fail_count;
    int                  outstanding;
    int                  gap_pct;
    int                  ready_drop_pct;
    logic                long_hold_req;
    int                  cycle_count;

    avr_instruction_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    avr_decode_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("avr_instruction_decoder verification failed");
            $finish;
        end
    end

    // The receiver either drops ready at random or, on request, holds it low for a long stretch.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(negedge aclk);
                long_hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= ready_drop_pct);
            end
        end
    end

    // Called and left at a falling edge; the word is held until the block takes it.
    task automatic send_word(input logic [15:0] instr, input logic [15:0] nxt);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {nxt, instr};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] random_instruction();
        logic [15:0] w;
        logic [4:0]  reg_no;
        w = 16'($urandom);
        reg_no = 5'($urandom);
        case ($urandom_range(9))
            2: w[15:8] = 8'($urandom_range(1, 3));
            3: begin
                w[15:14] = 2'b00;
                w[13:10] = 4'($urandom_range(1, 11));
            end
            4: begin
                w[15:10] = $urandom_range(1) ? 6'b000011 : 6'b000111;
                {w[8], w[7:4]} = reg_no;
                {w[9], w[3:0]} = reg_no;
            end
            5: w[15:12] = 4'($urandom_range(3, 7));
            6: begin
                w[15] = 1'b1;
                w[14] = 1'b0;
                w[12] = 1'b0;
            end
            7: begin
                w[15:10] = 6'b100100;
                if ($urandom_range(7) != 0) begin
                    w[3:0] = 4'h0;
                end
            end
            8: w = $urandom_range(1) ? 16'h0000 : (16'h0001 << $urandom_range(15));
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        gap_pct = 0;
        ready_drop_pct = 0;
        long_hold_req = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        send_word(16'h0000, 16'hFFFF);
        send_word(16'h01FF, 16'h0000);
        send_word(16'h02FF, 16'h1234);
        send_word(16'h0377, 16'h0000);
        send_word(16'h0308, 16'h0000);
        send_word(16'h0380, 16'h0000);
        send_word(16'h03FF, 16'h0000);
        send_word(16'h0FFF, 16'h0000);
        send_word(16'h1C11, 16'h0000);
        send_word(16'h0400, 16'h0000);
        send_word(16'h0800, 16'h0000);
        send_word(16'h0C01, 16'h0000);
        send_word(16'h1000, 16'h0000);
        send_word(16'h1400, 16'h0000);
        send_word(16'h1800, 16'h0000);
        send_word(16'h1FFE, 16'h0000);
        send_word(16'h2000, 16'h0000);
        send_word(16'h2400, 16'h0000);
        send_word(16'h2800, 16'h0000);
        send_word(16'h2FFF, 16'h0000);
        send_word(16'h3000, 16'hFFFF);
        send_word(16'h4FFF, 16'h0000);
        send_word(16'h5A5A, 16'h0000);
        send_word(16'h6000, 16'h0000);
        send_word(16'h7FFF, 16'h0000);
        send_word(16'h8000, 16'h0000);
        send_word(16'hAFFF, 16'h0000);
        send_word(16'h9000, 16'hFFFF);
        send_word(16'h93F0, 16'hA5A5);
        send_word(16'h9001, 16'hFFFF);
        send_word(16'hFFFF, 16'hFFFF);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  ready_drop_pct = 0;  end
                1: begin gap_pct = 51; ready_drop_pct = 0;  end
                2: begin gap_pct = 0;  ready_drop_pct = 51; end
                default: begin gap_pct = 22; ready_drop_pct = 22; end
            endcase
            for (int i = 0; i < PhaseWords; i++) begin
                if (phase == 0 && i == 100) begin
                    long_hold_req = 1'b1;
                end
                if (phase == 2 && i == 140) begin
                    s_tvalid <= 1'b0;
                    @(negedge aclk);
                    while (outstanding != 0) @(negedge aclk);
                end
                send_word(random_instruction(), 16'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("avr_instruction_decoder verification clean");
        end else begin
            $display("avr_instruction_decoder verification failed");
        end
        $finish;
    end

endmodule

/* avr_instruction_decoder.f */
src/avrid_pkg.sv
src/avrid_decode.sv
src/avr_instruction_decoder.sv
bench/avr_decode_checker.sv
bench/tb_top.sv
